### hw/rtl/jnl_pkg.sv
`timescale 1ns / 1ps

package jnl_pkg;

	// Phase of the number being recognized.
	typedef enum logic [3:0] {
		PH_START = 4'd0,
		PH_SIGN  = 4'd1,
		PH_ZERO  = 4'd2,
		PH_INT   = 4'd3,
		PH_POINT = 4'd4,
		PH_FRAC  = 4'd5,
		PH_EMARK = 4'd6,
		PH_ESIGN = 4'd7,
		PH_EDIG  = 4'd8
	} jnl_phase_t;

	// Kind of result reported for each character transaction.
	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_TERM  = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} jnl_kind_t;

	// Error codes reported with KIND_ERROR.
	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_SIGN   = 3'd1,
		ERR_DIGIT  = 3'd2,
		ERR_POINT  = 3'd3,
		ERR_EXP    = 3'd4,
		ERR_SYMBOL = 3'd5
	} jnl_err_t;

	// Characters with a role in the number grammar.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_LOW_E = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Payload of an input character transaction.
	typedef struct packed {
		logic [7:0] char_in;
		logic       source_end;
	} jnl_char_t;

	// Payload of a result transaction.
	typedef struct packed {
		jnl_kind_t  result_kind;
		logic [7:0] text_char;
		jnl_err_t   error_code;
	} jnl_result_t;

endpackage

### hw/rtl/jnl_if.sv
`timescale 1ns / 1ps

// Character stream into the lexer.
interface jnl_char_if import jnl_pkg::*; ();
	logic      valid;
	logic      ready;
	jnl_char_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Result stream out of the lexer.
interface jnl_result_if import jnl_pkg::*; ();
	logic        valid;
	logic        ready;
	jnl_result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/jnl_step.sv
`timescale 1ns / 1ps

// Next phase and result for one character, given the current phase.
module jnl_step import jnl_pkg::*; (
	input  jnl_phase_t  phase,
	input  jnl_char_t   item,
	output jnl_phase_t  next_phase,
	output jnl_result_t result
);

	logic is_sign;
	logic is_digit;
	logic is_point;
	logic is_emark;
	logic complete;

	// Character classes.
	assign is_sign  = (item.char_in == CH_MINUS) || (item.char_in == CH_PLUS);
	assign is_digit = (item.char_in >= CH_ZERO) && (item.char_in <= CH_NINE);
	assign is_point = (item.char_in == CH_POINT);
	assign is_emark = (item.char_in == CH_LOW_E) || (item.char_in == CH_UP_E);
	assign complete = (phase == PH_ZERO) || (phase == PH_INT) ||
	                  (phase == PH_FRAC) || (phase == PH_EDIG);

	// Decide the transition. Every path that does not accept the character
	// returns to the start phase.
	always_comb begin
		next_phase         = PH_START;
		result.result_kind = KIND_ERROR;
		result.text_char   = '0;
		result.error_code  = ERR_NONE;
		priority if (item.source_end) begin
			result.result_kind = KIND_END;
		end else if (is_sign) begin
			if (phase == PH_START) begin
				next_phase = PH_SIGN;
			end else if (phase == PH_EMARK) begin
				next_phase = PH_ESIGN;
			end else begin
				result.error_code = ERR_SIGN;
			end
		end else if (is_digit) begin
			unique case (phase)
				PH_START, PH_SIGN: begin
					next_phase = (item.char_in == CH_ZERO) ? PH_ZERO : PH_INT;
				end
				PH_INT: next_phase = PH_INT;
				PH_POINT, PH_FRAC: next_phase = PH_FRAC;
				PH_EMARK, PH_ESIGN, PH_EDIG: next_phase = PH_EDIG;
				default: result.error_code = ERR_DIGIT;
			endcase
		end else if (is_point) begin
			if ((phase == PH_ZERO) || (phase == PH_INT)) begin
				next_phase = PH_POINT;
			end else begin
				result.error_code = ERR_POINT;
			end
		end else if (is_emark) begin
			if ((phase == PH_ZERO) || (phase == PH_INT) || (phase == PH_FRAC)) begin
				next_phase = PH_EMARK;
			end else begin
				result.error_code = ERR_EXP;
			end
		end else if (complete) begin
			result.result_kind = KIND_TERM;
		end else begin
			result.error_code = ERR_SYMBOL;
		end

		// An accepted character leaves a phase other than start and is echoed.
		if (!item.source_end && (next_phase != PH_START)) begin
			result.result_kind = KIND_CHAR;
			result.text_char   = item.char_in;
		end
	end

endmodule

### hw/rtl/json_number_lexer_top.sv
`timescale 1ns / 1ps

// JSON number lexer.
//
// The chars channel carries one source byte per transaction, or an
// end-of-source mark. For every character transaction exactly one result
// transaction leaves on the tokens channel: the echoed character, an end by
// terminator, an end by source end, or an error with its code.
//
// A result is valid in the cycle after its character is taken. While the
// receiver is ready, one character is taken per cycle; the phase register
// is updated through a combinational decision step, and the result register
// hands off to the receiver.
//
// When the receiver stalls, the result stays in the output register and
// chars.ready drops until the result is taken; a new character is taken in
// the same cycle that the waiting result leaves.
//
// Reset clears the phase to the start phase and empties the result register.
module json_number_lexer_top import jnl_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	jnl_char_if.sink      chars,
	jnl_result_if.source  tokens
);

	jnl_phase_t  phase_q;
	jnl_phase_t  next_phase;
	jnl_result_t step_result;
	logic        out_valid_q;
	jnl_result_t out_data_q;
	logic        take;

	// Ready while the result register is empty or being emptied.
	assign chars.ready = !out_valid_q || tokens.ready;
	assign take        = chars.valid && chars.ready;

	jnl_step u_step (
		.phase      (phase_q),
		.item       (chars.data),
		.next_phase (next_phase),
		.result     (step_result)
	);

	// Phase and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= next_phase;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= step_result;
		end
	end

	assign tokens.valid = out_valid_q;
	assign tokens.data  = out_data_q;

endmodule

### hw/rtl/jnl_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the lexer.
module jnl_checker import jnl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input jnl_char_t   in_data,
	input logic        out_valid,
	input logic        out_ready,
	input jnl_result_t out_data
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// An end-of-source transaction yields an end result in the next cycle.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.source_end |=>
			out_valid && (out_data.result_kind == KIND_END))
		else $error("source end not reported");

	// Only echoed characters carry text.
	a_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_kind != KIND_CHAR) |->
			(out_data.text_char == 8'h00))
		else $error("text on a non-character result");

	// Only errors carry an error code, and errors always carry one.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.result_kind == KIND_ERROR) ==
			(out_data.error_code != ERR_NONE)))
		else $error("error code does not match result kind");

endmodule

bind json_number_lexer_top jnl_checker u_jnl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_data   (chars.data),
	.out_valid (tokens.valid),
	.out_ready (tokens.ready),
	.out_data  (tokens.data)
);

### verif/json_number_lexer_top_tb.sv
`timescale 1ns / 1ps

module json_number_lexer_top_tb;
	import jnl_pkg::*;

	localparam int DIRECTED_MAX  = 27;
	localparam int RANDOM_ITEMS  = 400;
	localparam int IDLE_LIMIT    = 1000;
	localparam int REPORT_LIMIT  = 30;
	localparam int DRAIN_CYCLES  = 8;

	logic clk = 1'b0;
	logic arst_n;

	jnl_char_if   chars_if();
	jnl_result_if tokens_if();

	json_number_lexer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.tokens (tokens_if.source)
	);

	// Characters waiting to be sent, and the tokens the lexer owes us.
	jnl_char_t   pending_chars[$];
	jnl_result_t expected_tokens[$];

	// Phase of the number as this bench sees it.
	jnl_phase_t lex_phase;

	int total_chars;
	int chars_taken;
	int mismatches = 0;
	int gap_left;
	int burst_left;
	int stall_mode;
	int mode_left;
	int idle_cycles;
	logic [2:0] stall_tick;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// An error sends the lexer back to the start phase.
	function automatic jnl_result_t lex_error(input jnl_err_t code);
		jnl_result_t res;
		res.result_kind = KIND_ERROR;
		res.text_char   = 8'h00;
		res.error_code  = code;
		lex_phase       = PH_START;
		return res;
	endfunction

	// Advance the number phase by one character and return the token it gives.
	function automatic jnl_result_t lex_step(input jnl_char_t item);
		jnl_result_t res;
		logic [7:0]  c;
		c               = item.char_in;
		res.result_kind = KIND_CHAR;
		res.text_char   = c;
		res.error_code  = ERR_NONE;
		if (item.source_end) begin
			res.result_kind = KIND_END;
			res.text_char   = 8'h00;
			lex_phase       = PH_START;
		end else if (c == CH_MINUS || c == CH_PLUS) begin
			case (lex_phase)
				PH_START: lex_phase = PH_SIGN;
				PH_EMARK: lex_phase = PH_ESIGN;
				default:  res = lex_error(ERR_SIGN);
			endcase
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			case (lex_phase)
				PH_START, PH_SIGN: begin
					if (c == CH_ZERO)
						lex_phase = PH_ZERO;
					else
						lex_phase = PH_INT;
				end
				PH_INT:                      lex_phase = PH_INT;
				PH_POINT, PH_FRAC:           lex_phase = PH_FRAC;
				PH_EMARK, PH_ESIGN, PH_EDIG: lex_phase = PH_EDIG;
				default:                     res = lex_error(ERR_DIGIT);
			endcase
		end else if (c == CH_POINT) begin
			if (lex_phase == PH_ZERO || lex_phase == PH_INT)
				lex_phase = PH_POINT;
			else
				res = lex_error(ERR_POINT);
		end else if (c == CH_LOW_E || c == CH_UP_E) begin
			if (lex_phase == PH_ZERO || lex_phase == PH_INT || lex_phase == PH_FRAC)
				lex_phase = PH_EMARK;
			else
				res = lex_error(ERR_EXP);
		end else if (lex_phase == PH_ZERO || lex_phase == PH_INT ||
				lex_phase == PH_FRAC || lex_phase == PH_EDIG) begin
			res.result_kind = KIND_TERM;
			res.text_char   = 8'h00;
			lex_phase       = PH_START;
		end else begin
			res = lex_error(ERR_SYMBOL);
		end
		return res;
	endfunction

	task automatic push_char(input logic [7:0] c);
		jnl_char_t item;
		item.char_in    = c;
		item.source_end = 1'b0;
		pending_chars.push_back(item);
	endtask

	// The character field is ignored on an end mark, so it carries noise.
	task automatic push_source_end();
		jnl_char_t item;
		item.char_in    = 8'($urandom_range(0, 255));
		item.source_end = 1'b1;
		pending_chars.push_back(item);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	task automatic push_digit(input int lo);
		push_char(CH_ZERO + 8'($urandom_range(lo, 9)));
	endtask

	// A byte that plays no part in the number grammar.
	function automatic logic [7:0] random_terminator();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_PLUS ||
				c == CH_POINT || c == CH_LOW_E || c == CH_UP_E)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// A byte that is likely to land in the wrong place of a number.
	function automatic logic [7:0] random_intruder();
		case ($urandom_range(0, 5))
			0:       return CH_MINUS;
			1:       return CH_PLUS;
			2:       return CH_POINT;
			3:       return ($urandom_range(0, 1) != 0) ? CH_LOW_E : CH_UP_E;
			4:       return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One number with random content; a broken one gets stray bytes inside.
	task automatic push_number(input bit broken);
		case ($urandom_range(0, 2))
			0:       push_char(CH_MINUS);
			1:       push_char(CH_PLUS);
			default: ;
		endcase
		if (broken && $urandom_range(0, 2) == 0)
			push_char(random_intruder());
		if ($urandom_range(0, 3) == 0) begin
			push_char(CH_ZERO);
		end else begin
			push_digit(1);
			repeat ($urandom_range(0, 4)) push_digit(0);
		end
		if (broken && $urandom_range(0, 2) == 0)
			push_char(random_intruder());
		if ($urandom_range(0, 1) != 0) begin
			push_char(CH_POINT);
			repeat ($urandom_range(1, 4)) push_digit(0);
		end
		if ($urandom_range(0, 2) == 0) begin
			push_char(($urandom_range(0, 1) != 0) ? CH_LOW_E : CH_UP_E);
			if (broken && $urandom_range(0, 2) == 0)
				push_char(random_intruder());
			case ($urandom_range(0, 2))
				0:       push_char(CH_MINUS);
				1:       push_char(CH_PLUS);
				default: ;
			endcase
			repeat ($urandom_range(1, 3)) push_digit(0);
		end
		if ($urandom_range(0, 3) == 0)
			push_source_end();
		else
			push_char(random_terminator());
	endtask

	task automatic report_mismatch(input string what, input int want, input int got);
		if (mismatches < REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		mismatches++;
	endtask

	// Character driver: sends pending transactions in bursts separated by gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid <= 1'b0;
			chars_if.data  <= '0;
			gap_left       <= 0;
			burst_left     <= 0;
			chars_taken    <= 0;
			lex_phase      = PH_START;
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				expected_tokens.push_back(lex_step(chars_if.data));
				chars_taken <= chars_taken + 1;
			end
			if (chars_if.valid && !chars_if.ready) begin
				// The offered transaction is held until it is taken.
			end else if (gap_left != 0) begin
				chars_if.valid <= 1'b0;
				gap_left       <= gap_left - 1;
			end else if (pending_chars.size() != 0) begin
				chars_if.valid <= 1'b1;
				chars_if.data  <= pending_chars.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				chars_if.valid <= 1'b0;
			end
		end
	end

	// Token monitor: checks each taken transaction and stalls on its own pattern.
	always @(posedge clk or negedge arst_n) begin
		jnl_result_t want;
		if (!arst_n) begin
			tokens_if.ready <= 1'b0;
			stall_mode      <= 0;
			mode_left       <= 0;
			stall_tick      <= '0;
		end else begin
			if (tokens_if.valid && tokens_if.ready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("unexpected token, kind", -1,
						int'(tokens_if.data.result_kind));
				end else begin
					want = expected_tokens.pop_front();
					if (tokens_if.data.result_kind !== want.result_kind)
						report_mismatch("result_kind", int'(want.result_kind),
							int'(tokens_if.data.result_kind));
					if (tokens_if.data.text_char !== want.text_char)
						report_mismatch("text_char", int'(want.text_char),
							int'(tokens_if.data.text_char));
					if (tokens_if.data.error_code !== want.error_code)
						report_mismatch("error_code", int'(want.error_code),
							int'(tokens_if.data.error_code));
				end
			end
			stall_tick <= stall_tick + 3'd1;
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       tokens_if.ready <= 1'b1;
				1:       tokens_if.ready <= ($urandom_range(0, 1) != 0);
				2:       tokens_if.ready <= ($urandom_range(0, 3) == 0);
				default: tokens_if.ready <= (stall_tick < 3'd5);
			endcase
		end
	end

	// Watchdog: too long without any transaction on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready) ||
				(tokens_if.valid && tokens_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		int pick;
		arst_n = 1'b0;

		// Directed part: every phase, every error and every kind of end.
		push_text("-0.5e+12,");
		push_text("+7E3");
		push_source_end();
		push_text("01");
		push_text("5-");
		push_text(".");
		push_text("1.e");
		push_text("-x");
		push_char(8'hFF);
		push_char(8'h00);
		push_source_end();

		// Random part: mostly numbers, some broken ones, some noise.
		while (pending_chars.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				push_number(1'b0);
			else if (pick < 17)
				push_number(1'b1);
			else if (pick < 19)
				push_char(8'($urandom_range(0, 255)));
			else
				push_source_end();
		end
		total_chars = pending_chars.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (chars_taken < total_chars || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### json_number_lexer_top.f
hw/rtl/jnl_pkg.sv
hw/rtl/jnl_if.sv
hw/rtl/jnl_step.sv
hw/rtl/json_number_lexer_top.sv
hw/rtl/jnl_checker.sv
verif/json_number_lexer_top_tb.sv
